FILE: hw/rtl/tmcr_pkg.sv
package tmcr_pkg;

  // Geometry in 1/256 pixel units.
  localparam int Sub         = 256;
  localparam int TilePixels  = 32;
  localparam int BoxPixels   = 60;
  localparam int BoxHalf     = 30;
  localparam int MaxCols     = 64;
  localparam int MaxRows     = 64;

  localparam int TileSpan    = TilePixels * Sub;
  localparam int TileShift   = $clog2(TileSpan);
  localparam int TileHalf    = TilePixels * (Sub / 2);
  localparam int BoxFull     = BoxPixels * Sub;
  localparam int BoxHalfSub  = BoxHalf * Sub;
  localparam int MinDist     = BoxHalfSub + TileHalf;
  localparam int CenterOfs   = BoxHalfSub - TileHalf;

  localparam int ColW        = $clog2(MaxCols);
  localparam int RowW        = $clog2(MaxRows);
  localparam int MapDepth    = MaxCols * MaxRows;
  localparam int MapAddrW    = ColW + RowW;

  localparam int PosW        = 24;
  localparam int CornerW     = PosW + 1;
  localparam int IdxW        = CornerW - TileShift;
  localparam int WorkW       = 28;
  localparam int CfgW        = 7;

  typedef enum logic {
    REQ_WRITE   = 1'b0,
    REQ_RESOLVE = 1'b1
  } req_e;

  typedef enum logic {
    REG_MAP_COLS = 1'b0,
    REG_MAP_ROWS = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CAPT,
    ST_DIST,
    ST_MOVE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            load;
    logic            calc;
    logic            move;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
  } push_ctrl_t;

  // Tile index of a box edge, or of the far edge when far is set.
  // The arithmetic shift gives the floor division by the tile span.
  function automatic logic signed [IdxW-1:0] corner_idx(input logic signed [PosW-1:0] pos,
                                                        input logic far);
    logic signed [CornerW-1:0] edge_pos;
    edge_pos = CornerW'(pos) + (far ? CornerW'(BoxFull) : CornerW'(0));
    return edge_pos[CornerW-1:TileShift];
  endfunction

endpackage

FILE: hw/rtl/tile_map_collision_resolve.sv
// Map write: the tile is written on acceptance; ST_DONE then loads the result.
// Resolve: four corner reads, ST_CAPT, ST_DIST and ST_MOVE per solid in-range
// corner (0..4 of them), then ST_DONE. Requests are taken only in ST_IDLE, after
// the last result is loaded. The four corner lookups share the single read port
// of the tile map; all pushes use one shared unit. After reset the map is cleared
// to empty, 4096 tiles, one per cycle; no request is taken (register writes are).
module tile_map_collision_resolve (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: tile_col[5:0], tile_row[11:6], tile_solid[12],
  // pos_x[36:13], pos_y[60:37], zero[63:61]
  input  logic [63:0] s_axis_tdata,
  // tuser: req_type[0]
  input  logic        s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: new_x[23:0], new_y[47:24], hit[48], zero[55:49]
  output logic [55:0] m_axis_tdata,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tmcr_pkg::*;

  state_e state_q, state_d;

  // Register file. Sizes above the stored map act as the stored size.
  logic [CfgW-1:0] map_cols_q, map_rows_q;
  logic [CfgW-1:0] cols_used, rows_used;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cols_q <= CfgW'(MaxCols);
      map_rows_q <= CfgW'(MaxRows);
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_MAP_COLS: map_cols_q <= pwdata[CfgW-1:0];
        REG_MAP_ROWS: map_rows_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_MAP_COLS: prdata = 32'(map_cols_q);
      REG_MAP_ROWS: prdata = 32'(map_rows_q);
      default:      prdata = '0;
    endcase
  end

  assign cols_used = (map_cols_q > CfgW'(MaxCols)) ? CfgW'(MaxCols) : map_cols_q;
  assign rows_used = (map_rows_q > CfgW'(MaxRows)) ? CfgW'(MaxRows) : map_rows_q;

  // Input transaction fields.
  logic                   in_acc;
  logic [ColW-1:0]        in_col;
  logic [RowW-1:0]        in_row;
  logic                   in_solid;
  logic signed [PosW-1:0] in_x, in_y;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_col        = s_axis_tdata[5:0];
  assign in_row        = s_axis_tdata[11:6];
  assign in_solid      = s_axis_tdata[12];
  assign in_x          = s_axis_tdata[36:13];
  assign in_y          = s_axis_tdata[60:37];

  // Sequencer registers. The original position stays put: the corner tiles
  // always come from it, while the pushes act on the working position.
  logic signed [PosW-1:0] px_q, py_q;
  logic [MapAddrW-1:0]    clr_q, clr_d;
  logic [1:0]             k_q, k_d;
  logic [3:0]             hm_q, hm_d;
  logic                   hit_q, hit_d;
  logic                   pend_q, pend_ok_q;
  logic [1:0]             pend_k_q;
  logic [1:0]             sel_k, k_cur;

  // Lowest corner still waiting for its push; corner order is kept.
  always_comb begin
    sel_k = 2'd3;
    for (int i = 3; i >= 0; i--) begin
      if (hm_q[i]) begin
        sel_k = 2'(i);
      end
    end
  end

  assign k_cur = (state_q == ST_READ) ? k_q : sel_k;

  // Corner tile of the current corner and its range check.
  logic signed [IdxW-1:0] cx, cy;
  logic                   in_range;

  always_comb begin
    cx       = corner_idx(px_q, k_cur[0]);
    cy       = corner_idx(py_q, k_cur[1]);
    in_range = !cx[IdxW-1] && !cy[IdxW-1]
            && ($unsigned(cx) < {{(IdxW-CfgW){1'b0}}, cols_used})
            && ($unsigned(cy) < {{(IdxW-CfgW){1'b0}}, rows_used});
  end

  // Tile map memory: clearing pass and map writes share the write port, the
  // corner lookups use the read port.
  logic                ram_we, ram_wdata, ram_re, ram_rdata;
  logic [MapAddrW-1:0] ram_waddr, ram_raddr;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = 1'b0;
    if (state_q == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (in_acc && s_axis_tuser == REQ_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = {in_row, in_col};
      ram_wdata = in_solid;
    end
  end

  assign ram_re    = (state_q == ST_READ);
  assign ram_raddr = {cy[RowW-1:0], cx[ColW-1:0]};

  tmcr_ram #(
    .Width (1),
    .Depth (MapDepth)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Push unit.
  push_ctrl_t             push_ctrl;
  logic signed [PosW-1:0] res_x, res_y;

  always_comb begin
    push_ctrl.load = in_acc;
    push_ctrl.calc = (state_q == ST_DIST);
    push_ctrl.move = (state_q == ST_MOVE);
    push_ctrl.col  = cx[ColW-1:0];
    push_ctrl.row  = cy[RowW-1:0];
  end

  tmcr_push u_push (
    .clk_i   (clk_i),
    .ctrl_i  (push_ctrl),
    .pos_x_i (in_x),
    .pos_y_i (in_y),
    .new_x_o (res_x),
    .new_y_o (res_y)
  );

  // Output register: holds a finished result while the next item is taken.
  logic                   out_vld_q;
  logic signed [PosW-1:0] out_x_q, out_y_q;
  logic                   out_hit_q;
  logic                   out_load;

  assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  // Collected solid corners; a lookup result lands in the cycle after its read.
  always_comb begin
    hm_d  = hm_q;
    hit_d = hit_q;
    if (in_acc) begin
      hm_d  = '0;
      hit_d = 1'b0;
    end
    if (pend_q && pend_ok_q && ram_rdata) begin
      hm_d[pend_k_q] = 1'b1;
      hit_d          = 1'b1;
    end
    if (state_q == ST_MOVE) begin
      hm_d[sel_k] = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    k_d     = k_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == MapAddrW'(MapDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        k_d = 2'd0;
        if (in_acc) begin
          state_d = (s_axis_tuser == REQ_WRITE) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        k_d = k_q + 1'b1;
        if (k_q == 2'd3) begin
          state_d = ST_CAPT;
        end
      end
      ST_CAPT: state_d = (hm_d != '0) ? ST_DIST : ST_DONE;
      ST_DIST: state_d = ST_MOVE;
      ST_MOVE: state_d = (hm_d != '0) ? ST_DIST : ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      k_q       <= '0;
      hm_q      <= '0;
      hit_q     <= 1'b0;
      pend_q    <= 1'b0;
      pend_ok_q <= 1'b0;
      pend_k_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      k_q       <= k_d;
      hm_q      <= hm_d;
      hit_q     <= hit_d;
      pend_q    <= ram_re;
      pend_ok_q <= in_range;
      pend_k_q  <= k_q;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= in_x;
      py_q <= in_y;
    end
    if (out_load) begin
      out_x_q   <= res_x;
      out_y_q   <= res_y;
      out_hit_q <= hit_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_hit_q, out_y_q, out_x_q};

  // The map is never written while corner lookups are in flight.
  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_CAPT) |-> !ram_we)
    else $error("tile map written during corner lookup");

  // Every push step follows its distance step.
  a_move_after_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE) |-> ($past(state_q) == ST_DIST))
    else $error("push without distance step");

  // A distance step always has a collected solid corner to work on.
  a_dist_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIST) |-> (hm_q != '0 && hit_q))
    else $error("distance step without a solid corner");

  // A finished result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !out_load)
    else $error("result register overwritten");

endmodule

FILE: hw/rtl/tmcr_ram.sv
module tmcr_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tmcr_push.sv
module tmcr_push (
  input  logic                              clk_i,
  input  tmcr_pkg::push_ctrl_t              ctrl_i,
  input  logic signed [tmcr_pkg::PosW-1:0]  pos_x_i,
  input  logic signed [tmcr_pkg::PosW-1:0]  pos_y_i,
  output logic signed [tmcr_pkg::PosW-1:0]  new_x_o,
  output logic signed [tmcr_pkg::PosW-1:0]  new_y_o
);
  import tmcr_pkg::*;

  localparam logic signed [WorkW-1:0] PosMax = WorkW'((1 << (PosW - 1)) - 1);
  localparam logic signed [WorkW-1:0] PosMin = -WorkW'(1 << (PosW - 1));
  localparam logic signed [WorkW-1:0] MinD   = WorkW'(MinDist);
  localparam logic signed [WorkW-1:0] Ofs    = WorkW'(CenterOfs);

  logic signed [WorkW-1:0] wx_q, wx_d, wy_q, wy_d;
  logic signed [WorkW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [WorkW-1:0] base_x, base_y, xd, yd;

  // Distance from the box center to the tile center on each axis.
  always_comb begin
    base_x = signed'(WorkW'({ctrl_i.col, {TileShift{1'b0}}}));
    base_y = signed'(WorkW'({ctrl_i.row, {TileShift{1'b0}}}));
    dx_d   = wx_q + Ofs - base_x;
    dy_d   = wy_q + Ofs - base_y;
  end

  // Overlap on each axis, then the push along the smaller one.
  always_comb begin
    xd   = dx_q[WorkW-1] ? MinD + dx_q : MinD - dx_q;
    yd   = dy_q[WorkW-1] ? MinD + dy_q : MinD - dy_q;
    wx_d = wx_q;
    wy_d = wy_q;
    if (ctrl_i.load) begin
      wx_d = WorkW'(pos_x_i);
      wy_d = WorkW'(pos_y_i);
    end else if (ctrl_i.move && xd > 0 && yd > 0) begin
      if (xd < yd) begin
        wx_d = dx_q[WorkW-1] ? wx_q - xd : wx_q + xd;
      end else begin
        wy_d = dy_q[WorkW-1] ? wy_q - yd : wy_q + yd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q <= wx_d;
    wy_q <= wy_d;
    if (ctrl_i.calc) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  always_comb begin
    if (wx_q > PosMax) begin
      new_x_o = PosMax[PosW-1:0];
    end else if (wx_q < PosMin) begin
      new_x_o = PosMin[PosW-1:0];
    end else begin
      new_x_o = wx_q[PosW-1:0];
    end
    if (wy_q > PosMax) begin
      new_y_o = PosMax[PosW-1:0];
    end else if (wy_q < PosMin) begin
      new_y_o = PosMin[PosW-1:0];
    end else begin
      new_y_o = wy_q[PosW-1:0];
    end
  end

endmodule
